### hdl/jlx_pkg.sv
// shared types, character codes and result codes for the lenient json lexer
package jlx_pkg;

  localparam int CP_W  = 21;
  localparam int MAX_RES = 3;
  localparam int CNT_W = 2;

  // lexer modes
  localparam logic [2:0] M_OUT        = 3'd0;
  localparam logic [2:0] M_SLASH      = 3'd1;
  localparam logic [2:0] M_BLOCK      = 3'd2;
  localparam logic [2:0] M_BLOCK_STAR = 3'd3;
  localparam logic [2:0] M_LINE       = 3'd4;
  localparam logic [2:0] M_STR        = 3'd5;
  localparam logic [2:0] M_ESC        = 3'd6;
  localparam logic [2:0] M_HEX        = 3'd7;

  // result kinds
  localparam logic [2:0] K_BARE    = 3'd0;
  localparam logic [2:0] K_OPEN    = 3'd1;
  localparam logic [2:0] K_CONTENT = 3'd2;
  localparam logic [2:0] K_CLOSE   = 3'd3;
  localparam logic [2:0] K_ERROR   = 3'd4;
  localparam logic [2:0] K_END     = 3'd5;

  // error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_COMMENT = 3'd1;
  localparam logic [2:0] E_STRING  = 3'd2;
  localparam logic [2:0] E_ESCAPE  = 3'd3;
  localparam logic [2:0] E_HEX     = 3'd4;

  // character codes
  localparam logic [CP_W-1:0] CP_TAB    = 21'h00009;
  localparam logic [CP_W-1:0] CP_LF     = 21'h0000A;
  localparam logic [CP_W-1:0] CP_CR     = 21'h0000D;
  localparam logic [CP_W-1:0] CP_SPACE  = 21'h00020;
  localparam logic [CP_W-1:0] CP_DQUOTE = 21'h00022;
  localparam logic [CP_W-1:0] CP_HASH   = 21'h00023;
  localparam logic [CP_W-1:0] CP_SQUOTE = 21'h00027;
  localparam logic [CP_W-1:0] CP_STAR   = 21'h0002A;
  localparam logic [CP_W-1:0] CP_SLASH  = 21'h0002F;
  localparam logic [CP_W-1:0] CP_BSLASH = 21'h0005C;
  localparam logic [CP_W-1:0] CP_LC_B   = 21'h00062;
  localparam logic [CP_W-1:0] CP_LC_F   = 21'h00066;
  localparam logic [CP_W-1:0] CP_LC_N   = 21'h0006E;
  localparam logic [CP_W-1:0] CP_LC_R   = 21'h00072;
  localparam logic [CP_W-1:0] CP_LC_T   = 21'h00074;
  localparam logic [CP_W-1:0] CP_LC_U   = 21'h00075;
  localparam logic [CP_W-1:0] CP_BOM    = 21'h0FEFF;
  localparam logic [CP_W-1:0] CP_BS     = 21'h00008;
  localparam logic [CP_W-1:0] CP_FF     = 21'h0000C;

  typedef struct packed {
    logic [2:0]      kind;
    logic [CP_W-1:0] code_point;
    logic            after_gap;
    logic [2:0]      error_code;
  } jlx_res_t;

  typedef struct packed {
    jlx_res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]       cnt;
  } jlx_bundle_t;

  function automatic jlx_res_t mk_res(input logic [2:0] kind, input logic [CP_W-1:0] cp,
                                      input logic gap, input logic [2:0] err);
    jlx_res_t r;
    r.kind       = kind;
    r.code_point = cp;
    r.after_gap  = gap;
    r.error_code = err;
    return r;
  endfunction

endpackage

### hdl/jlx_step.sv
// lexer state registers and per-character transition logic
module jlx_step (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic [jlx_pkg::CP_W-1:0] char_in,
  input  logic                     is_last,
  output jlx_pkg::jlx_bundle_t     bundle
);
  import jlx_pkg::*;

  logic [2:0]  mode_r, mode_nxt;
  logic        quote_r, quote_nxt;
  logic [15:0] hexv_r, hexv_nxt;
  logic [1:0]  hexc_r, hexc_nxt;
  logic        gap_r, gap_nxt;
  logic        start_r, start_nxt;
  logic        failed_r, failed_nxt;

  logic [CNT_W-1:0] n;
  jlx_res_t [MAX_RES-1:0] res;
  logic        do_out;
  logic        is_ws;
  logic        hex_ok;
  logic [3:0]  hex_d;
  logic [CP_W-1:0] esc_v;
  logic [CP_W-1:0] qchar;

  assign is_ws = (char_in == CP_TAB) || (char_in == CP_SPACE) ||
                 (char_in == CP_LF) || (char_in == CP_CR);
  assign qchar = quote_r ? CP_SQUOTE : CP_DQUOTE;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = '0;
    if (char_in >= 21'h30 && char_in <= 21'h39) begin
      hex_d = 4'(char_in - 21'h30);
    end else if (char_in >= 21'h41 && char_in <= 21'h46) begin
      hex_d = 4'(char_in - 21'h37);
    end else if (char_in >= 21'h61 && char_in <= 21'h66) begin
      hex_d = 4'(char_in - 21'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    unique if (char_in == CP_LC_T) begin
      esc_v = CP_TAB;
    end else if (char_in == CP_LC_B) begin
      esc_v = CP_BS;
    end else if (char_in == CP_LC_N) begin
      esc_v = CP_LF;
    end else if (char_in == CP_LC_R) begin
      esc_v = CP_CR;
    end else if (char_in == CP_LC_F) begin
      esc_v = CP_FF;
    end else begin
      esc_v = char_in;
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    quote_nxt  = quote_r;
    hexv_nxt   = hexv_r;
    hexc_nxt   = hexc_r;
    gap_nxt    = gap_r;
    start_nxt  = start_r;
    failed_nxt = failed_r;
    n          = '0;
    res        = '0;
    do_out     = 1'b0;

    if (failed_r) begin
      if (is_last) begin
        res[0]     = mk_res(K_END, '0, 1'b0, E_NONE);
        n          = CNT_W'(1);
        mode_nxt   = M_OUT;
        quote_nxt  = 1'b0;
        hexv_nxt   = '0;
        hexc_nxt   = '0;
        gap_nxt    = 1'b0;
        start_nxt  = 1'b1;
        failed_nxt = 1'b0;
      end
    end else begin
      start_nxt = 1'b0;
      // byte order mark is dropped only as the first character of a text
      if (!(start_r && char_in == CP_BOM)) begin
        unique case (mode_r)
          M_OUT: do_out = 1'b1;
          M_SLASH: begin
            if (char_in == CP_STAR) begin
              gap_nxt  = 1'b1;
              mode_nxt = M_BLOCK;
            end else if (char_in == CP_SLASH) begin
              gap_nxt  = 1'b1;
              mode_nxt = M_LINE;
            end else begin
              res[n]   = mk_res(K_BARE, CP_SLASH, gap_r, E_NONE);
              n        = n + 1'b1;
              gap_nxt  = 1'b0;
              mode_nxt = M_OUT;
              do_out   = 1'b1;
            end
          end
          M_BLOCK: begin
            if (char_in == CP_STAR) mode_nxt = M_BLOCK_STAR;
          end
          M_BLOCK_STAR: begin
            if (char_in == CP_SLASH) mode_nxt = M_OUT;
            else if (char_in != CP_STAR) mode_nxt = M_BLOCK;
          end
          M_LINE: begin
            if (char_in == CP_LF || char_in == CP_CR) mode_nxt = M_OUT;
          end
          M_STR: begin
            if (char_in == qchar) begin
              res[n]   = mk_res(K_CLOSE, char_in, 1'b0, E_NONE);
              n        = n + 1'b1;
              mode_nxt = M_OUT;
            end else if (char_in == CP_BSLASH) begin
              mode_nxt = M_ESC;
            end else begin
              res[n] = mk_res(K_CONTENT, char_in, 1'b0, E_NONE);
              n      = n + 1'b1;
            end
          end
          M_ESC: begin
            if (char_in == CP_LC_U) begin
              mode_nxt = M_HEX;
              hexv_nxt = '0;
              hexc_nxt = '0;
            end else begin
              mode_nxt = M_STR;
              res[n]   = mk_res(K_CONTENT, esc_v, 1'b0, E_NONE);
              n        = n + 1'b1;
            end
          end
          default: begin
            if (!hex_ok) begin
              res[n]     = mk_res(K_ERROR, '0, 1'b0, E_HEX);
              n          = n + 1'b1;
              failed_nxt = 1'b1;
            end else if (hexc_r == 2'd3) begin
              res[n]   = mk_res(K_CONTENT, {5'd0, hexv_r[11:0], hex_d}, 1'b0, E_NONE);
              n        = n + 1'b1;
              hexv_nxt = '0;
              hexc_nxt = '0;
              mode_nxt = M_STR;
            end else begin
              hexv_nxt = {hexv_r[11:0], hex_d};
              hexc_nxt = hexc_r + 1'b1;
            end
          end
        endcase

        if (do_out) begin
          if (is_ws) begin
            gap_nxt = 1'b1;
          end else if (char_in == CP_SLASH) begin
            mode_nxt = M_SLASH;
          end else if (char_in == CP_HASH) begin
            gap_nxt  = 1'b1;
            mode_nxt = M_LINE;
          end else if (char_in == CP_DQUOTE || char_in == CP_SQUOTE) begin
            quote_nxt = (char_in == CP_SQUOTE);
            gap_nxt   = 1'b0;
            mode_nxt  = M_STR;
            res[n]    = mk_res(K_OPEN, char_in, 1'b0, E_NONE);
            n         = n + 1'b1;
          end else begin
            res[n]  = mk_res(K_BARE, char_in, gap_nxt, E_NONE);
            n       = n + 1'b1;
            gap_nxt = 1'b0;
          end
        end
      end

      if (is_last) begin
        if (!failed_nxt) begin
          unique case (mode_nxt)
            M_SLASH: begin
              res[n] = mk_res(K_BARE, CP_SLASH, gap_nxt, E_NONE);
              n      = n + 1'b1;
              res[n] = mk_res(K_END, '0, 1'b0, E_NONE);
              n      = n + 1'b1;
            end
            M_BLOCK, M_BLOCK_STAR: begin
              res[n] = mk_res(K_ERROR, '0, 1'b0, E_COMMENT);
              n      = n + 1'b1;
            end
            M_STR: begin
              res[n] = mk_res(K_ERROR, '0, 1'b0, E_STRING);
              n      = n + 1'b1;
            end
            M_ESC, M_HEX: begin
              res[n] = mk_res(K_ERROR, '0, 1'b0, E_ESCAPE);
              n      = n + 1'b1;
            end
            default: begin
              res[n] = mk_res(K_END, '0, 1'b0, E_NONE);
              n      = n + 1'b1;
            end
          endcase
        end
        // a text ends: back to reset state for the next one
        mode_nxt   = M_OUT;
        quote_nxt  = 1'b0;
        hexv_nxt   = '0;
        hexc_nxt   = '0;
        gap_nxt    = 1'b0;
        start_nxt  = 1'b1;
        failed_nxt = 1'b0;
      end
    end
  end

  assign bundle.res = res;
  assign bundle.cnt = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_OUT;
      quote_r  <= 1'b0;
      hexv_r   <= '0;
      hexc_r   <= '0;
      gap_r    <= 1'b0;
      start_r  <= 1'b1;
      failed_r <= 1'b0;
    end else if (take) begin
      mode_r   <= mode_nxt;
      quote_r  <= quote_nxt;
      hexv_r   <= hexv_nxt;
      hexc_r   <= hexc_nxt;
      gap_r    <= gap_nxt;
      start_r  <= start_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

### hdl/jlx_obuf.sv
// result register that holds one item's results and sends them one per transfer
module jlx_obuf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  jlx_pkg::jlx_bundle_t     bundle,
  output logic                     can_load,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_kind,
  output logic [jlx_pkg::CP_W-1:0] out_code_point,
  output logic                     out_after_gap,
  output logic [2:0]               out_error_code,
  output logic                     out_last_result
);
  import jlx_pkg::*;

  jlx_res_t [MAX_RES-1:0] res_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             at_last;
  logic             out_fire;

  assign out_valid       = (cnt_r != '0);
  assign at_last         = (idx_r == cnt_r - 1'b1);
  assign out_fire        = out_valid && !out_stall;
  // a new item may enter as the final pending result leaves
  assign can_load        = !out_valid || (out_fire && at_last);
  assign out_kind        = res_r[idx_r].kind;
  assign out_code_point  = res_r[idx_r].code_point;
  assign out_after_gap   = res_r[idx_r].after_gap;
  assign out_error_code  = res_r[idx_r].error_code;
  assign out_last_result = at_last;

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (out_fire) begin
      if (at_last) begin
        cnt_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (load && bundle.cnt != '0) begin
      cnt_nxt = bundle.cnt;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && bundle.cnt != '0) res_r <= bundle.res;
  end

endmodule

### hdl/lenient_json_lexer.sv
// lenient json lexer: one code point in per transfer, up to three results out
// latency: the first result of an item is presented the cycle after its transfer
// throughput: one item per cycle while each item yields at most one result and out_stall is low;
//   an item yielding k results holds the result register for k output transfers
// reset: synchronous rst_n clears the lexer state and empties the result register
module lenient_json_lexer (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [jlx_pkg::CP_W-1:0] in_char_in,
  input  logic                     in_is_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               out_kind,
  output logic [jlx_pkg::CP_W-1:0] out_code_point,
  output logic                     out_after_gap,
  output logic [2:0]               out_error_code,
  output logic                     out_last_result
);
  import jlx_pkg::*;

  jlx_bundle_t bundle;
  logic        can_load;
  logic        in_fire;

  assign in_stall = !can_load;
  assign in_fire  = in_valid && can_load;

  jlx_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_fire),
    .char_in (in_char_in),
    .is_last (in_is_last),
    .bundle  (bundle)
  );

  jlx_obuf u_obuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_fire),
    .bundle          (bundle),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_code_point  (out_code_point),
    .out_after_gap   (out_after_gap),
    .out_error_code  (out_error_code),
    .out_last_result (out_last_result)
  );

endmodule
